>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the LCD request queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/lcdq_pkg.sv
// Shared types, codes and reset values of the LCD request queue.
`default_nettype none
package lcdq_pkg;

  // Queue storage
  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_W      = 10;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Payload types
  typedef logic [1:0] req_type_t;
  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic [2:0] phase_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FUNCSET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPCTRL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd5;

  // Register reset values
  localparam byte_t RST_FUNCSET  = 8'h38;
  localparam byte_t RST_DISPCTRL = 8'h0C;
  localparam byte_t RST_CLEAR    = 8'h01;
  localparam byte_t RST_ENTRY    = 8'h06;
  localparam byte_t RST_POWERUP  = 8'd30;
  localparam byte_t RST_HOLD     = 8'd2;

  // Sequencer phases
  localparam phase_t PH_START    = 3'd0;
  localparam phase_t PH_FUNCSET  = 3'd1;
  localparam phase_t PH_DISPCTRL = 3'd2;
  localparam phase_t PH_CLEAR    = 3'd3;
  localparam phase_t PH_ENTRY    = 3'd4;
  localparam phase_t PH_IDLE     = 3'd5;
  localparam phase_t PH_RUNNING  = 3'd6;

  // Result status codes
  localparam status_t ST_TICK   = 2'd0;
  localparam status_t ST_STORED = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  // Input modes
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_ENQUEUE = 1'b1;

  // Fixed phase lengths
  localparam byte_t LEN_ONE = 8'd1;
  localparam byte_t LEN_TWO = 8'd2;

endpackage
`default_nettype wire

>>> design/lcdq_ifs.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface lcdq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  lcdq_pkg::req_type_t  req_type;
  lcdq_pkg::byte_t      req_value;

  modport source (output valid, mode, req_type, req_value, input ready);
  modport sink   (input valid, mode, req_type, req_value, output ready);
endinterface

interface lcdq_out_if;
  logic                 valid;
  logic                 ready;
  lcdq_pkg::status_t    status;
  logic                 pin_en;
  logic                 pin_rs;
  logic                 pin_rw;
  lcdq_pkg::byte_t      pin_data;
  lcdq_pkg::phase_t     phase_code;

  modport source (output valid, status, pin_en, pin_rs, pin_rw, pin_data, phase_code,
                  input ready);
  modport sink   (input valid, status, pin_en, pin_rs, pin_rw, pin_data, phase_code,
                  output ready);
endinterface
`default_nettype wire

>>> design/char_lcd_init_and_request_queue.sv
// Character LCD init sequencer and request queue, top level.
//
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      mode, req_type, req_value
//  out_ch    out   valid/ready      status, pin_en, pin_rs, pin_rw, pin_data, phase_code
//  config    in    APB, pready=1    six 8-bit registers at byte address 4*i
//
//  One request per cycle sustained while out_ch is not stalled; a request is captured in
//  the input register and its result is then loaded into the output register.
//  The queue RAM read address follows the next read index; a one-entry bypass
//  covers a write to the head slot in the same cycle.
//  Reset is synchronous; the queue storage is not cleared and needs no sweep.
//  A stalled result holds the input register, which then backs up in_ch.ready.
`default_nettype none
`include "assert_macros.svh"
module char_lcd_init_and_request_queue #(
  parameter int QUEUE_DEPTH = lcdq_pkg::QUEUE_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  lcdq_in_if.sink                                  in_ch,
  lcdq_out_if.source                               out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lcdq_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire logic [lcdq_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic      [lcdq_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                     pready
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic            en;
    logic            rs;
    logic            rw;
    lcdq_pkg::byte_t data;
  } pins_t;

  // configuration registers
  lcdq_pkg::byte_t funcset_r, dispctrl_r, clear_r, entry_r, powerup_r, hold_r;

  // sequencer and queue state
  lcdq_pkg::phase_t phase_r, phase_nxt;
  logic             wait_r, wait_nxt;
  lcdq_pkg::byte_t  ticks_r, ticks_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt, rd_idx_r, rd_idx_nxt;
  pins_t            pins_r, pins_nxt;
  lcdq_pkg::status_t status_nxt;

  // input and output stages
  logic                 s1_v_r, out_v_r;
  logic                 s1_mode_r;
  lcdq_pkg::req_type_t  s1_type_r;
  lcdq_pkg::byte_t      s1_value_r;
  lcdq_pkg::status_t    out_status_r;
  pins_t                out_pins_r;
  lcdq_pkg::phase_t     out_phase_r;
  logic                 s1_adv, s1_go, in_go;

  // queue storage
  logic                                ram_we;
  logic [lcdq_pkg::ITEM_W-1:0]         ram_wdata, ram_rdata, head;
  logic                                byp_v_r;
  logic [lcdq_pkg::ITEM_W-1:0]         byp_data_r;

  // config decode
  logic                              cfg_we;
  logic [lcdq_pkg::CFG_IDX_W-1:0]    cfg_idx;

  // timed send helper
  lcdq_pkg::req_type_t  tp_type;
  lcdq_pkg::byte_t      tp_value;
  pins_t                tp_pins;
  lcdq_pkg::byte_t      tp_ticks;
  logic                 tp_wait, tp_done;

  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic             q_full;

  // handshake
  assign s1_adv       = !out_v_r || out_ch.ready;
  assign s1_go        = s1_v_r && s1_adv;
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign in_go        = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_v_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.pin_en     = out_pins_r.en;
  assign out_ch.pin_rs     = out_pins_r.rs;
  assign out_ch.pin_rw     = out_pins_r.rw;
  assign out_ch.pin_data   = out_pins_r.data;
  assign out_ch.phase_code = out_phase_r;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[lcdq_pkg::CFG_ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      lcdq_pkg::REG_FUNCSET:  prdata = {24'd0, funcset_r};
      lcdq_pkg::REG_DISPCTRL: prdata = {24'd0, dispctrl_r};
      lcdq_pkg::REG_CLEAR:    prdata = {24'd0, clear_r};
      lcdq_pkg::REG_ENTRY:    prdata = {24'd0, entry_r};
      lcdq_pkg::REG_POWERUP:  prdata = {24'd0, powerup_r};
      lcdq_pkg::REG_HOLD:     prdata = {24'd0, hold_r};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      funcset_r  <= lcdq_pkg::RST_FUNCSET;
      dispctrl_r <= lcdq_pkg::RST_DISPCTRL;
      clear_r    <= lcdq_pkg::RST_CLEAR;
      entry_r    <= lcdq_pkg::RST_ENTRY;
      powerup_r  <= lcdq_pkg::RST_POWERUP;
      hold_r     <= lcdq_pkg::RST_HOLD;
    end else if (cfg_we) begin
      case (cfg_idx)
        lcdq_pkg::REG_FUNCSET:  funcset_r  <= pwdata[7:0];
        lcdq_pkg::REG_DISPCTRL: dispctrl_r <= pwdata[7:0];
        lcdq_pkg::REG_CLEAR:    clear_r    <= pwdata[7:0];
        lcdq_pkg::REG_ENTRY:    entry_r    <= pwdata[7:0];
        lcdq_pkg::REG_POWERUP:  powerup_r  <= pwdata[7:0];
        lcdq_pkg::REG_HOLD:     hold_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // queue index arithmetic
  assign wr_inc = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;
  assign q_full = (wr_inc == rd_idx_r);

  // head of queue, with bypass for a write into the slot being read
  assign head = byp_v_r ? byp_data_r : ram_rdata;

  // command for the current timed phase
  always_comb begin
    tp_type  = '0;
    tp_value = '0;
    case (phase_r)
      lcdq_pkg::PH_FUNCSET:  tp_value = funcset_r;
      lcdq_pkg::PH_DISPCTRL: tp_value = dispctrl_r;
      lcdq_pkg::PH_CLEAR:    tp_value = clear_r;
      lcdq_pkg::PH_ENTRY:    tp_value = entry_r;
      lcdq_pkg::PH_RUNNING: begin
        tp_type  = head[9:8];
        tp_value = head[7:0];
      end
      default: ;
    endcase
  end

  // timed phase: send on first tick, drop EN on the last one
  always_comb begin
    tp_pins  = pins_r;
    tp_ticks = ticks_r;
    if (!wait_r) begin
      tp_pins = '{en: 1'b1, rs: tp_type[1], rw: tp_type[0], data: tp_value};
    end
    if (ticks_r > lcdq_pkg::LEN_ONE) begin
      tp_ticks = ticks_r - 1'b1;
      tp_wait  = 1'b1;
      tp_done  = 1'b0;
    end else begin
      tp_pins.en = 1'b0;
      tp_wait    = 1'b0;
      tp_done    = 1'b1;
    end
  end

  // step logic for the request in the input register
  always_comb begin
    phase_nxt  = phase_r;
    wait_nxt   = wait_r;
    ticks_nxt  = ticks_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    pins_nxt   = pins_r;
    status_nxt = lcdq_pkg::ST_TICK;
    ram_we     = 1'b0;
    ram_wdata  = {s1_type_r, s1_value_r};
    if (s1_go) begin
      if (s1_mode_r == lcdq_pkg::MODE_ENQUEUE) begin
        if (q_full) begin
          status_nxt = lcdq_pkg::ST_FULL;
        end else begin
          status_nxt = lcdq_pkg::ST_STORED;
          ram_we     = 1'b1;
          wr_idx_nxt = wr_inc;
        end
      end else begin
        unique case (phase_r) inside
          lcdq_pkg::PH_START: begin
            if (ticks_r > lcdq_pkg::LEN_ONE) begin
              ticks_nxt = ticks_r - 1'b1;
              wait_nxt  = 1'b1;
            end else begin
              phase_nxt = lcdq_pkg::PH_FUNCSET;
              ticks_nxt = lcdq_pkg::LEN_ONE;
              wait_nxt  = 1'b0;
            end
          end
          lcdq_pkg::PH_FUNCSET, lcdq_pkg::PH_DISPCTRL, lcdq_pkg::PH_CLEAR: begin
            pins_nxt  = tp_pins;
            ticks_nxt = tp_ticks;
            wait_nxt  = tp_wait;
            if (tp_done) begin
              phase_nxt = phase_r + 1'b1;
              ticks_nxt = (phase_r == lcdq_pkg::PH_DISPCTRL) ? lcdq_pkg::LEN_TWO
                                                             : lcdq_pkg::LEN_ONE;
            end
          end
          lcdq_pkg::PH_ENTRY: begin
            pins_nxt  = tp_pins;
            ticks_nxt = tp_ticks;
            wait_nxt  = tp_wait;
            if (tp_done) begin
              if (wr_idx_r == rd_idx_r) begin
                phase_nxt = lcdq_pkg::PH_IDLE;
              end else begin
                phase_nxt = lcdq_pkg::PH_RUNNING;
                ticks_nxt = hold_r;
              end
            end
          end
          lcdq_pkg::PH_RUNNING: begin
            pins_nxt  = tp_pins;
            ticks_nxt = tp_ticks;
            wait_nxt  = tp_wait;
            if (tp_done) begin
              rd_idx_nxt = rd_inc;
              if (wr_idx_r == rd_inc) begin
                phase_nxt = lcdq_pkg::PH_IDLE;
              end else begin
                phase_nxt = lcdq_pkg::PH_RUNNING;
                ticks_nxt = hold_r;
              end
            end
          end
          default: begin
            // idle (and the unused code): only look at the queue
            if (wr_idx_r == rd_idx_r) begin
              phase_nxt = lcdq_pkg::PH_IDLE;
            end else begin
              phase_nxt = lcdq_pkg::PH_RUNNING;
              ticks_nxt = hold_r;
            end
          end
        endcase
      end
    end else if (cfg_we && cfg_idx == lcdq_pkg::REG_POWERUP &&
                 phase_r == lcdq_pkg::PH_START && !wait_r) begin
      // power-up count rewritten before the first tick
      ticks_nxt = pwdata[7:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lcdq_pkg::PH_START;
      wait_r   <= 1'b0;
      ticks_r  <= lcdq_pkg::RST_POWERUP;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      pins_r   <= '0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      byp_v_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      wait_r   <= wait_nxt;
      ticks_r  <= ticks_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      pins_r   <= pins_nxt;
      if (in_go) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      byp_v_r <= ram_we && (wr_idx_r == rd_idx_nxt);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_mode_r  <= in_ch.mode;
      s1_type_r  <= in_ch.req_type;
      s1_value_r <= in_ch.req_value;
    end
    if (s1_go) begin
      out_status_r <= status_nxt;
      out_pins_r   <= pins_nxt;
      out_phase_r  <= phase_nxt;
    end
    byp_data_r <= ram_wdata;
  end

  lcdq_ram #(
    .WIDTH (lcdq_pkg::ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_idx_r),
    .wr_data (ram_wdata),
    .rd_addr (rd_idx_nxt),
    .rd_data (ram_rdata)
  );

  // a running phase always has a request at the head
  `ASSERT_CLK(a_running_nonempty, (phase_r == lcdq_pkg::PH_RUNNING) |-> (wr_idx_r != rd_idx_r), "running with empty queue")
  // EN is never high while waiting for power-up or idle
  `ASSERT_CLK(a_en_phase, !pins_r.en || (phase_r != lcdq_pkg::PH_START && phase_r != lcdq_pkg::PH_IDLE), "EN high outside a send phase")
  // a stored request advances the write index by one slot
  `ASSERT_CLK(a_store_advances, (ram_we) |=> (wr_idx_r == $past(wr_inc)), "write index did not advance")
  // a result leaves the input stage only toward a free or draining output
  `ASSERT_CLK(a_result_loaded, (s1_go) |=> (out_v_r && out_status_r == $past(status_nxt)), "result lost")
  // the config port never inserts wait states
  `ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule
`default_nettype wire

>>> design/lcdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lcdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> verif/tb_char_lcd_init_and_request_queue.sv
// Self-checking testbench for the character LCD init sequencer and request queue.
`timescale 1ns / 1ps
module tb_char_lcd_init_and_request_queue;
  import lcdq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int HOLD_OFF    = 120;
  // addresses past the last register, which the block ignores
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic      mode;
    req_type_t rtype;
    byte_t     rval;
  } lcd_req_t;

  typedef struct packed {
    status_t status;
    logic    en;
    logic    rs;
    logic    rw;
    byte_t   data;
    phase_t  phase;
  } lcd_pins_t;

  typedef struct packed {
    lcd_req_t  req;
    logic [4:0] reps;
    logic      typed;
    lcd_pins_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  lcdq_in_if  in_if ();
  lcdq_out_if out_if ();

  char_lcd_init_and_request_queue DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: sequencer, request queue, pins, register copy
  phase_t              seq_phase;
  bit                  seq_waiting;
  byte_t               seq_ticks;
  int                  q_wr, q_rd;
  logic [ITEM_W-1:0]   q_mem [QUEUE_DEPTH];
  logic                pin_en, pin_rs, pin_rw;
  byte_t               pin_data;
  byte_t               reg_shadow [6];

  lcd_pins_t pin_states_due [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  logic      hold_off_ask;

  // Directed walk: reset registers, powerup forced to zero before the first tick
  dir_row_t dir_table [22] = '{
    '{'{MODE_ENQUEUE, 2'd3, 8'hFF}, 5'd1, 1'b1, '{ST_STORED, 1'b0, 1'b0, 1'b0, 8'h00, PH_START}},
    '{'{MODE_ENQUEUE, 2'd0, 8'h00}, 5'd1, 1'b1, '{ST_STORED, 1'b0, 1'b0, 1'b0, 8'h00, PH_START}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h00, PH_FUNCSET}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h38, PH_DISPCTRL}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h0C, PH_CLEAR}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b1, 1'b0, 1'b0, 8'h01, PH_CLEAR}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h01, PH_ENTRY}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h06, PH_RUNNING}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b1, 1'b1, 1'b1, 8'hFF, PH_RUNNING}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b1, 1'b1, 8'hFF, PH_RUNNING}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b1, 1'b0, 1'b0, 8'h00, PH_RUNNING}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h00, PH_IDLE}},
    // idle tick with a busy payload: payload ignored, queue still empty
    '{'{MODE_TICK,    2'd3, 8'hFF}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h00, PH_IDLE}},
    '{'{MODE_ENQUEUE, 2'd2, 8'h80}, 5'd1, 1'b1, '{ST_STORED, 1'b0, 1'b0, 1'b0, 8'h00, PH_IDLE}},
    // leaving idle sends nothing yet
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b0, 1'b0, 1'b0, 8'h00, PH_RUNNING}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b1, '{ST_TICK, 1'b1, 1'b1, 1'b0, 8'h80, PH_RUNNING}},
    // fill to one free slot, then the queue refuses
    '{'{MODE_ENQUEUE, 2'd1, 8'h55}, 5'd14, 1'b1, '{ST_STORED, 1'b1, 1'b1, 1'b0, 8'h80, PH_RUNNING}},
    '{'{MODE_ENQUEUE, 2'd1, 8'hAA}, 5'd1, 1'b1, '{ST_FULL, 1'b1, 1'b1, 1'b0, 8'h80, PH_RUNNING}},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b0, '0},
    '{'{MODE_TICK,    2'd0, 8'h00}, 5'd1, 1'b0, '0},
    '{'{MODE_ENQUEUE, 2'd2, 8'h00}, 5'd1, 1'b0, '0},
    '{'{MODE_ENQUEUE, 2'd0, 8'hFF}, 5'd1, 1'b1, '{ST_FULL, 1'b1, 1'b0, 1'b1, 8'h55, PH_RUNNING}}
  };

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
    mismatches++;
  endtask

  // Queue empty -> idle, else start the head request with the current hold length
  function automatic void select_queue_phase();
    if (q_wr == q_rd) begin
      seq_phase = PH_IDLE;
    end else begin
      seq_phase = PH_RUNNING;
      seq_ticks = reg_shadow[REG_HOLD];
    end
  endfunction

  // Send on the first tick of a phase, drop EN on the last; returns phase done
  function automatic bit timed_send(input req_type_t t, input byte_t v);
    if (!seq_waiting) begin
      pin_rs   = t[1];
      pin_rw   = t[0];
      pin_data = v;
      pin_en   = 1'b1;
    end
    if (seq_ticks > LEN_ONE) begin
      seq_ticks   = seq_ticks - LEN_ONE;
      seq_waiting = 1'b1;
      return 1'b0;
    end
    pin_en      = 1'b0;
    seq_waiting = 1'b0;
    return 1'b1;
  endfunction

  // Pin levels and phase after one request
  function automatic lcd_pins_t lcd_ctrl_step(input lcd_req_t r);
    lcd_pins_t         o;
    logic [ITEM_W-1:0] head;
    o.status = ST_TICK;
    if (r.mode == MODE_ENQUEUE) begin
      if ((q_rd + QUEUE_DEPTH - q_wr) % QUEUE_DEPTH == 1) begin
        o.status = ST_FULL;
      end else begin
        q_mem[q_wr] = {r.rtype, r.rval};
        q_wr        = (q_wr + 1) % QUEUE_DEPTH;
        o.status    = ST_STORED;
      end
    end else begin
      case (seq_phase)
        PH_START: begin
          if (seq_ticks > LEN_ONE) begin
            seq_ticks   = seq_ticks - LEN_ONE;
            seq_waiting = 1'b1;
          end else begin
            seq_phase   = PH_FUNCSET;
            seq_ticks   = LEN_ONE;
            seq_waiting = 1'b0;
          end
        end
        PH_FUNCSET: begin
          if (timed_send(2'b00, reg_shadow[REG_FUNCSET])) begin
            seq_phase = PH_DISPCTRL;
            seq_ticks = LEN_ONE;
          end
        end
        PH_DISPCTRL: begin
          if (timed_send(2'b00, reg_shadow[REG_DISPCTRL])) begin
            seq_phase = PH_CLEAR;
            seq_ticks = LEN_TWO;
          end
        end
        PH_CLEAR: begin
          if (timed_send(2'b00, reg_shadow[REG_CLEAR])) begin
            seq_phase = PH_ENTRY;
            seq_ticks = LEN_ONE;
          end
        end
        PH_ENTRY: begin
          if (timed_send(2'b00, reg_shadow[REG_ENTRY])) select_queue_phase();
        end
        PH_RUNNING: begin
          head = q_mem[q_rd];
          if (timed_send(head[9:8], head[7:0])) begin
            q_rd = (q_rd + 1) % QUEUE_DEPTH;
            select_queue_phase();
          end
        end
        default: select_queue_phase();
      endcase
    end
    o.en    = pin_en;
    o.rs    = pin_rs;
    o.rw    = pin_rw;
    o.data  = pin_data;
    o.phase = seq_phase;
    return o;
  endfunction

  // One request on in_if; bursts of random length separated by random gaps
  task automatic push_request(input lcd_req_t r, input logic typed, input lcd_pins_t want);
    lcd_pins_t got_pred;
    int        gap;
    in_if.valid     <= 1'b1;
    in_if.mode      <= r.mode;
    in_if.req_type  <= r.rtype;
    in_if.req_value <= r.rval;
    do @(posedge clk); while (!in_if.ready);
    got_pred = lcd_ctrl_step(r);
    pin_states_due.push_back(typed ? want : got_pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // APB transfer; psel stays up so transfers can run back to back
  task automatic reg_access(input bit wr, input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx <= REG_HOLD) begin
        reg_shadow[idx] = wdata[7:0];
        // powerup count reloads only before the first tick
        if (idx == REG_POWERUP && seq_phase == PH_START && !seq_waiting)
          seq_ticks = wdata[7:0];
      end
    end else if (prdata !== {{(CFG_DATA_W-8){1'b0}}, reg_shadow[idx]}) begin
      flag_mismatch("register readback", {8'h00, reg_shadow[idx]}, prdata[15:0]);
    end
  endtask

  task automatic settle_outputs();
    while (pin_states_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result check and receiver stall pattern
  int stall_pct = 0, pattern_left = 0, stall_hold = 0;
  bit hold_off_done = 1'b0;

  always @(posedge clk) begin
    lcd_pins_t due;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pin_states_due.size() == 0) begin
        flag_mismatch("result with no request pending", 16'h0, {13'h0, out_if.phase_code});
      end else begin
        due = pin_states_due.pop_front();
        if (out_if.status !== due.status)
          flag_mismatch("status", {14'h0, due.status}, {14'h0, out_if.status});
        if (out_if.pin_en !== due.en)
          flag_mismatch("pin_en", {15'h0, due.en}, {15'h0, out_if.pin_en});
        if (out_if.pin_rs !== due.rs)
          flag_mismatch("pin_rs", {15'h0, due.rs}, {15'h0, out_if.pin_rs});
        if (out_if.pin_rw !== due.rw)
          flag_mismatch("pin_rw", {15'h0, due.rw}, {15'h0, out_if.pin_rw});
        if (out_if.pin_data !== due.data)
          flag_mismatch("pin_data", {8'h0, due.data}, {8'h0, out_if.pin_data});
        if (out_if.phase_code !== due.phase)
          flag_mismatch("phase_code", {13'h0, due.phase}, {13'h0, out_if.phase_code});
      end
    end
    if (stall_hold > 0) begin
      out_if.ready <= 1'b0;
      stall_hold   <= stall_hold - 1;
    end else if (hold_off_ask && !hold_off_done) begin
      // long hold-off so the block backs up into in_ch
      out_if.ready  <= 1'b0;
      stall_hold    <= HOLD_OFF;
      hold_off_done <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 30;
          default: stall_pct <= 70;
        endcase
        pattern_left <= 40;
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL char_lcd_init_and_request_queue");
      $finish;
    end
  end

  // Enqueue share and hold length per random phase; -1 picks a random hold
  int enq_share [PHASES] = '{50, 30, 70, 10, 50, 90, 40, 5};
  int hold_pick [PHASES] = '{1, 0, 3, 255, 2, 1, 4, -1};

  initial begin
    lcd_req_t r;
    int       p, n, k;
    logic [CFG_DATA_W-1:0] v;

    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= MODE_TICK;
    in_if.req_type  <= '0;
    in_if.req_value <= '0;
    hold_off_ask    <= 1'b0;

    reg_shadow[REG_FUNCSET]  = RST_FUNCSET;
    reg_shadow[REG_DISPCTRL] = RST_DISPCTRL;
    reg_shadow[REG_CLEAR]    = RST_CLEAR;
    reg_shadow[REG_ENTRY]    = RST_ENTRY;
    reg_shadow[REG_POWERUP]  = RST_POWERUP;
    reg_shadow[REG_HOLD]     = RST_HOLD;
    seq_phase   = PH_START;
    seq_waiting = 1'b0;
    seq_ticks   = RST_POWERUP;
    q_wr        = 0;
    q_rd        = 0;
    pin_en      = 1'b0;
    pin_rs      = 1'b0;
    pin_rw      = 1'b0;
    pin_data    = 8'h00;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then a zero powerup count before the first tick and writes to the spare addresses
    for (k = 0; k < 6; k++) reg_access(1'b0, 3'(k), '0);
    reg_access(1'b1, REG_POWERUP, 32'd0);
    reg_access(1'b1, REG_SPARE_A, 32'hFF);
    reg_access(1'b1, REG_SPARE_B, 32'h5A);
    psel    <= 1'b0;
    penable <= 1'b0;

    foreach (dir_table[i])
      repeat (dir_table[i].reps) push_request(dir_table[i].req, dir_table[i].typed,
                                              dir_table[i].want);

    for (p = 0; p < PHASES; p++) begin
      in_if.valid <= 1'b0;
      settle_outputs();
      for (k = 0; k <= REG_ENTRY; k++) begin
        v = (p == 0) ? 32'h00 : (p == 1) ? 32'hFF : $urandom_range(0, 255);
        reg_access(1'b1, 3'(k), v);
      end
      v = (p == 0) ? 32'd255 : (p == 1) ? 32'd1 : $urandom_range(0, 255);
      reg_access(1'b1, REG_POWERUP, v);
      v = (hold_pick[p] < 0) ? $urandom_range(1, 255) : hold_pick[p];
      reg_access(1'b1, REG_HOLD, v);
      for (k = 0; k < 6; k++) reg_access(1'b0, 3'(k), '0);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (p == 5) hold_off_ask <= 1'b1;

      for (n = 0; n < PHASE_ITEMS; n++) begin
        r.mode  = ($urandom_range(0, 99) < enq_share[p]) ? MODE_ENQUEUE : MODE_TICK;
        r.rtype = req_type_t'($urandom_range(0, 3));
        case ($urandom_range(0, 7))
          0:       r.rval = 8'h00;
          1:       r.rval = 8'hFF;
          default: r.rval = byte_t'($urandom_range(0, 255));
        endcase
        push_request(r, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    settle_outputs();
    if (mismatches == 0)
      $display("PASS char_lcd_init_and_request_queue");
    else
      $display("FAIL char_lcd_init_and_request_queue");
    $finish;
  end

endmodule
